[rtl/core/rfvsl_pkg.sv]
// ----------------------------------------------------------------------------
// rfvsl_pkg
// Types, codes, reset values and the heading sine table of the rotated-frame
// velocity setpoint limiter.
// ----------------------------------------------------------------------------
package rfvsl_pkg;

   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SINE_INDEX_WIDTH = $clog2(SINE_TABLE_DEPTH);

   localparam logic [2:0] CMD_TRACK         = 3'd0;
   localparam logic [2:0] CMD_TRACK_NO_FF   = 3'd1;
   localparam logic [2:0] CMD_DESCEND       = 3'd2;
   localparam logic [2:0] CMD_DESCEND_NO_FF = 3'd3;
   localparam logic [2:0] CMD_LAND          = 3'd4;

   localparam logic [2:0] CSR_POSITION_GAIN     = 3'd0;
   localparam logic [2:0] CSR_SPEED_LONG_LIMITS = 3'd1;
   localparam logic [2:0] CSR_SPEED_LAT_LIMITS  = 3'd2;
   localparam logic [2:0] CSR_ACCEL_LONG_LIMITS = 3'd3;
   localparam logic [2:0] CSR_ACCEL_LAT_LIMITS  = 3'd4;
   localparam logic [2:0] CSR_VERT_SPEED_LIMITS = 3'd5;
   localparam logic [2:0] CSR_DESCENT_RATE      = 3'd6;

   localparam logic [15:0] POSITION_GAIN_RESET     = 16'd4096;
   localparam logic [31:0] SPEED_LONG_LIMITS_RESET = 32'd201389056;
   localparam logic [31:0] SPEED_LAT_LIMITS_RESET  = 32'd83950336;
   localparam logic [31:0] ACCEL_LONG_LIMITS_RESET = 32'd50396928;
   localparam logic [31:0] ACCEL_LAT_LIMITS_RESET  = 32'd16842496;
   localparam logic [31:0] VERT_SPEED_LIMITS_RESET = 32'd33619712;
   localparam logic [14:0] DESCENT_RATE_RESET      = 15'd128;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'h4000_0000;
   localparam logic [63:0] SERIES_DIVISORS [7] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
   };

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] base_pos_x;
      logic signed [31:0] base_pos_y;
      logic signed [31:0] own_pos_x;
      logic signed [31:0] own_pos_y;
      logic signed [15:0] base_vel_x;
      logic signed [15:0] base_vel_y;
      logic signed [15:0] base_acc_x;
      logic signed [15:0] base_acc_y;
      logic        [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] speed_sp_x;
      logic signed [15:0] speed_sp_y;
      logic signed [15:0] accel_sp_x;
      logic signed [15:0] accel_sp_y;
      logic signed [15:0] climb_sp;
   } rsp_type;

   typedef logic signed [15:0] sine_table_type [SINE_TABLE_DEPTH];

   // Q1.14 sine of each table phase: quadrant fold, Q30 Taylor series to x^15
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0] ph, q, r, x, t, pos, neg, s;
      int k, n;
      for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
         ph = (64'(k) << 32) / SINE_TABLE_DEPTH;
         q  = ph >> 30;
         r  = ph & 64'h3FFF_FFFF;
         if (q[0]) begin
            r = ONE_Q30 - r;
         end
         x   = (r * HALF_PI_Q30) >> 30;
         t   = x;
         pos = x;
         neg = 64'd0;
         for (n = 1; n <= 7; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / SERIES_DIVISORS[n - 1];
            if (n % 2 == 1) begin
               neg = neg + t;
            end else begin
               pos = pos + t;
            end
         end
         s = (pos > neg) ? pos - neg : 64'd0;
         if (s > ONE_Q30) begin
            s = ONE_Q30;
         end
         s = (s + 64'd32768) >> 16;
         tbl[k] = (q >= 64'd2) ? -16'(s) : 16'(s);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // nonnegative values bounded above only, negative values bounded below only
   function automatic logic signed [15:0] clamp_axis(input logic signed [33:0] v,
                                                     input logic [31:0] lims);
      logic signed [15:0] up;
      logic signed [15:0] lo;
      logic signed [15:0] res;
      up = lims[31:16];
      lo = lims[15:0];
      if (v >= 34'sd0) begin
         res = (v > 34'(up)) ? up : 16'(v);
      end else begin
         res = (v < 34'(lo)) ? lo : 16'(v);
      end
      return res;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] res;
      if (v > 19'sd32767) begin
         res = 16'sh7FFF;
      end else if (v < -19'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = 16'(v);
      end
      return res;
   endfunction

endpackage

[rtl/core/rotated_frame_velocity_setpoint_limiter_top.sv]
// ----------------------------------------------------------------------------
// rotated_frame_velocity_setpoint_limiter_top
// Seven-stage pipeline that forms horizontal speed and acceleration setpoints,
// bounds them in the heading frame and gives the bounded climb rate.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out. A new item can enter every cycle while
// the first stage is empty or moving on; each item passes through the seven
// register stages: error and sine lookup, gain multiply, feedforward add,
// forward rotation multiply, round and clamp, back rotation multiply, round
// and saturate. Each stage holds only while the stage after it is full and
// stalled. Configuration writes are meant for idle periods and take effect
// on the next cycle.
module rotated_frame_velocity_setpoint_limiter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rfvsl_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rfvsl_pkg::rsp_type  rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int NUM_STAGES = 7;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [32:0] ex;
      logic signed [32:0] ey;
      logic signed [15:0] bvx;
      logic signed [15:0] bvy;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } s1_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [49:0] px;
      logic signed [49:0] py;
      logic signed [15:0] bvx;
      logic signed [15:0] bvy;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } s2_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [30:0] sx;
      logic signed [30:0] sy;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } s3_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [46:0] sy_cs;
      logic signed [46:0] sx_sn;
      logic signed [46:0] sx_cs;
      logic signed [46:0] sy_sn;
      logic signed [31:0] ay_cs;
      logic signed [31:0] ax_sn;
      logic signed [31:0] ax_cs;
      logic signed [31:0] ay_sn;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } s4_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [15:0] lon_v;
      logic signed [15:0] lat_v;
      logic signed [15:0] lon_a;
      logic signed [15:0] lat_a;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } s5_type;

   typedef struct packed {
      logic        [2:0]  cmd;
      logic signed [31:0] v_lat_cs;
      logic signed [31:0] v_lon_sn;
      logic signed [31:0] v_lon_cs;
      logic signed [31:0] v_lat_sn;
      logic signed [31:0] a_lat_cs;
      logic signed [31:0] a_lon_sn;
      logic signed [31:0] a_lon_cs;
      logic signed [31:0] a_lat_sn;
   } s6_type;

   logic [15:0] position_gain_ff;
   logic [31:0] speed_long_limits_ff;
   logic [31:0] speed_lat_limits_ff;
   logic [31:0] accel_long_limits_ff;
   logic [31:0] accel_lat_limits_ff;
   logic [31:0] vert_speed_limits_ff;
   logic [14:0] descent_rate_ff;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] advance;

   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;
   s6_type             s6_ff, s6_in;
   rfvsl_pkg::rsp_type s7_ff, s7_in;

   logic [rfvsl_pkg::SINE_INDEX_WIDTH-1:0] sin_idx;
   logic [rfvsl_pkg::SINE_INDEX_WIDTH:0]   cos_sum;
   logic [rfvsl_pkg::SINE_INDEX_WIDTH-1:0] cos_idx;

   logic signed [49:0] rx_full;
   logic signed [49:0] ry_full;
   logic signed [29:0] rx;
   logic signed [29:0] ry;
   logic               feedforward;

   logic signed [47:0] lon_v_sum;
   logic signed [47:0] lat_v_sum;
   logic signed [32:0] lon_a_sum;
   logic signed [32:0] lat_a_sum;
   logic signed [33:0] lon_a_r;
   logic signed [33:0] lat_a_r;

   logic signed [32:0] vx_sum;
   logic signed [32:0] vy_sum;
   logic signed [32:0] ax_sum;
   logic signed [32:0] ay_sum;
   logic signed [16:0] climb_raw;
   logic signed [15:0] climb_up;
   logic signed [15:0] climb_lo;
   logic signed [15:0] climb_val;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         position_gain_ff     <= rfvsl_pkg::POSITION_GAIN_RESET;
         speed_long_limits_ff <= rfvsl_pkg::SPEED_LONG_LIMITS_RESET;
         speed_lat_limits_ff  <= rfvsl_pkg::SPEED_LAT_LIMITS_RESET;
         accel_long_limits_ff <= rfvsl_pkg::ACCEL_LONG_LIMITS_RESET;
         accel_lat_limits_ff  <= rfvsl_pkg::ACCEL_LAT_LIMITS_RESET;
         vert_speed_limits_ff <= rfvsl_pkg::VERT_SPEED_LIMITS_RESET;
         descent_rate_ff      <= rfvsl_pkg::DESCENT_RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rfvsl_pkg::CSR_POSITION_GAIN:     position_gain_ff     <= csr_wdata[15:0];
            rfvsl_pkg::CSR_SPEED_LONG_LIMITS: speed_long_limits_ff <= csr_wdata;
            rfvsl_pkg::CSR_SPEED_LAT_LIMITS:  speed_lat_limits_ff  <= csr_wdata;
            rfvsl_pkg::CSR_ACCEL_LONG_LIMITS: accel_long_limits_ff <= csr_wdata;
            rfvsl_pkg::CSR_ACCEL_LAT_LIMITS:  accel_lat_limits_ff  <= csr_wdata;
            rfvsl_pkg::CSR_VERT_SPEED_LIMITS: vert_speed_limits_ff <= csr_wdata;
            rfvsl_pkg::CSR_DESCENT_RATE:      descent_rate_ff      <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   always_comb begin
      advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
      valid_in[0] = advance[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = advance[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_ready = advance[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = s7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------- stage 1: position error, sine
   always_comb begin
      sin_idx = rfvsl_pkg::SINE_INDEX_WIDTH'(
         (32'(req_data.heading) * rfvsl_pkg::SINE_TABLE_DEPTH) >> 16);
      cos_sum = (rfvsl_pkg::SINE_INDEX_WIDTH + 1)'(sin_idx)
              + (rfvsl_pkg::SINE_INDEX_WIDTH + 1)'(rfvsl_pkg::SINE_TABLE_DEPTH / 4);
      if (cos_sum >= (rfvsl_pkg::SINE_INDEX_WIDTH + 1)'(rfvsl_pkg::SINE_TABLE_DEPTH)) begin
         cos_idx = rfvsl_pkg::SINE_INDEX_WIDTH'(
            cos_sum - (rfvsl_pkg::SINE_INDEX_WIDTH + 1)'(rfvsl_pkg::SINE_TABLE_DEPTH));
      end else begin
         cos_idx = rfvsl_pkg::SINE_INDEX_WIDTH'(cos_sum);
      end
      s1_in.cmd = req_data.cmd;
      s1_in.ex  = 33'(req_data.base_pos_x) - 33'(req_data.own_pos_x);
      s1_in.ey  = 33'(req_data.base_pos_y) - 33'(req_data.own_pos_y);
      s1_in.bvx = req_data.base_vel_x;
      s1_in.bvy = req_data.base_vel_y;
      s1_in.ax  = req_data.base_acc_x;
      s1_in.ay  = req_data.base_acc_y;
      s1_in.sn  = rfvsl_pkg::SINE_TABLE[sin_idx];
      s1_in.cs  = rfvsl_pkg::SINE_TABLE[cos_idx];
   end

   // ---------------------------------------------------- stage 2: gain
   always_comb begin
      s2_in.cmd = s1_ff.cmd;
      s2_in.px  = s1_ff.ex * $signed({1'b0, position_gain_ff});
      s2_in.py  = s1_ff.ey * $signed({1'b0, position_gain_ff});
      s2_in.bvx = s1_ff.bvx;
      s2_in.bvy = s1_ff.bvy;
      s2_in.ax  = s1_ff.ax;
      s2_in.ay  = s1_ff.ay;
      s2_in.sn  = s1_ff.sn;
      s2_in.cs  = s1_ff.cs;
   end

   // ------------------------------------------- stage 3: round, feedforward
   always_comb begin
      rx_full     = (s2_ff.px + 50'sd524288) >>> 20;
      ry_full     = (s2_ff.py + 50'sd524288) >>> 20;
      rx          = 30'(rx_full);
      ry          = 30'(ry_full);
      feedforward = (s2_ff.cmd == rfvsl_pkg::CMD_TRACK) ||
                    (s2_ff.cmd == rfvsl_pkg::CMD_DESCEND);
      s3_in.cmd = s2_ff.cmd;
      if (s2_ff.cmd == rfvsl_pkg::CMD_LAND) begin
         s3_in.sx = 31'(s2_ff.bvx);
         s3_in.sy = 31'(s2_ff.bvy);
      end else if (feedforward) begin
         s3_in.sx = 31'(rx) + 31'(s2_ff.bvx);
         s3_in.sy = 31'(ry) + 31'(s2_ff.bvy);
      end else begin
         s3_in.sx = 31'(rx);
         s3_in.sy = 31'(ry);
      end
      s3_in.ax = s2_ff.ax;
      s3_in.ay = s2_ff.ay;
      s3_in.sn = s2_ff.sn;
      s3_in.cs = s2_ff.cs;
   end

   // ------------------------------------- stage 4: rotate into heading frame
   always_comb begin
      s4_in.cmd   = s3_ff.cmd;
      s4_in.sy_cs = 47'(s3_ff.sy) * 47'(s3_ff.cs);
      s4_in.sx_sn = 47'(s3_ff.sx) * 47'(s3_ff.sn);
      s4_in.sx_cs = 47'(s3_ff.sx) * 47'(s3_ff.cs);
      s4_in.sy_sn = 47'(s3_ff.sy) * 47'(s3_ff.sn);
      s4_in.ay_cs = 32'(s3_ff.ay) * 32'(s3_ff.cs);
      s4_in.ax_sn = 32'(s3_ff.ax) * 32'(s3_ff.sn);
      s4_in.ax_cs = 32'(s3_ff.ax) * 32'(s3_ff.cs);
      s4_in.ay_sn = 32'(s3_ff.ay) * 32'(s3_ff.sn);
      s4_in.sn    = s3_ff.sn;
      s4_in.cs    = s3_ff.cs;
   end

   // ------------------------------------------------- stage 5: round, clamp
   always_comb begin
      lon_v_sum = 48'(s4_ff.sy_cs) + 48'(s4_ff.sx_sn) + 48'sd8192;
      lat_v_sum = 48'(s4_ff.sx_cs) - 48'(s4_ff.sy_sn) + 48'sd8192;
      lon_a_sum = 33'(s4_ff.ay_cs) + 33'(s4_ff.ax_sn) + 33'sd8192;
      lat_a_sum = 33'(s4_ff.ax_cs) - 33'(s4_ff.ay_sn) + 33'sd8192;
      lon_a_r   = 34'(lon_a_sum >>> 14);
      lat_a_r   = 34'(lat_a_sum >>> 14);
      s5_in.cmd   = s4_ff.cmd;
      s5_in.lon_v = rfvsl_pkg::clamp_axis(34'(lon_v_sum >>> 14), speed_long_limits_ff);
      s5_in.lat_v = rfvsl_pkg::clamp_axis(34'(lat_v_sum >>> 14), speed_lat_limits_ff);
      s5_in.lon_a = rfvsl_pkg::clamp_axis(lon_a_r, accel_long_limits_ff);
      s5_in.lat_a = rfvsl_pkg::clamp_axis(lat_a_r, accel_lat_limits_ff);
      s5_in.sn    = s4_ff.sn;
      s5_in.cs    = s4_ff.cs;
   end

   // ------------------------------------------------ stage 6: rotate back
   always_comb begin
      s6_in.cmd      = s5_ff.cmd;
      s6_in.v_lat_cs = 32'(s5_ff.lat_v) * 32'(s5_ff.cs);
      s6_in.v_lon_sn = 32'(s5_ff.lon_v) * 32'(s5_ff.sn);
      s6_in.v_lon_cs = 32'(s5_ff.lon_v) * 32'(s5_ff.cs);
      s6_in.v_lat_sn = 32'(s5_ff.lat_v) * 32'(s5_ff.sn);
      s6_in.a_lat_cs = 32'(s5_ff.lat_a) * 32'(s5_ff.cs);
      s6_in.a_lon_sn = 32'(s5_ff.lon_a) * 32'(s5_ff.sn);
      s6_in.a_lon_cs = 32'(s5_ff.lon_a) * 32'(s5_ff.cs);
      s6_in.a_lat_sn = 32'(s5_ff.lat_a) * 32'(s5_ff.sn);
   end

   // ------------------------------------- stage 7: round, saturate, select
   always_comb begin
      vx_sum = 33'(s6_ff.v_lat_cs) + 33'(s6_ff.v_lon_sn) + 33'sd8192;
      vy_sum = 33'(s6_ff.v_lon_cs) - 33'(s6_ff.v_lat_sn) + 33'sd8192;
      ax_sum = 33'(s6_ff.a_lat_cs) + 33'(s6_ff.a_lon_sn) + 33'sd8192;
      ay_sum = 33'(s6_ff.a_lon_cs) - 33'(s6_ff.a_lat_sn) + 33'sd8192;

      climb_raw = -$signed({2'b00, descent_rate_ff});
      climb_up  = vert_speed_limits_ff[31:16];
      climb_lo  = vert_speed_limits_ff[15:0];
      if (climb_raw > 17'(climb_up)) begin
         climb_val = climb_up;
      end else if (climb_raw < 17'(climb_lo)) begin
         climb_val = climb_lo;
      end else begin
         climb_val = 16'(climb_raw);
      end

      s7_in = '0;
      if (s6_ff.cmd inside {rfvsl_pkg::CMD_TRACK, rfvsl_pkg::CMD_TRACK_NO_FF,
                            rfvsl_pkg::CMD_DESCEND, rfvsl_pkg::CMD_DESCEND_NO_FF,
                            rfvsl_pkg::CMD_LAND}) begin
         s7_in.speed_sp_x = rfvsl_pkg::sat16(19'(vx_sum >>> 14));
         s7_in.speed_sp_y = rfvsl_pkg::sat16(19'(vy_sum >>> 14));
      end
      if (s6_ff.cmd == rfvsl_pkg::CMD_LAND) begin
         s7_in.accel_sp_x = rfvsl_pkg::sat16(19'(ax_sum >>> 14));
         s7_in.accel_sp_y = rfvsl_pkg::sat16(19'(ay_sum >>> 14));
      end
      if (s6_ff.cmd inside {rfvsl_pkg::CMD_DESCEND, rfvsl_pkg::CMD_DESCEND_NO_FF}) begin
         s7_in.climb_sp = climb_val;
      end
   end

   // ------------------------------------------------------ payload registers
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         s1_ff <= s1_in;
      end
      if (advance[1]) begin
         s2_ff <= s2_in;
      end
      if (advance[2]) begin
         s3_ff <= s3_in;
      end
      if (advance[3]) begin
         s4_ff <= s4_in;
      end
      if (advance[4]) begin
         s5_ff <= s5_in;
      end
      if (advance[5]) begin
         s6_ff <= s6_in;
      end
      if (advance[6]) begin
         s7_ff <= s7_in;
      end
   end

   // ------------------------------------------------------------- assertions
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted transfer did not reach the first stage");

   a_accel_zero_unless_land: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && advance[6] && (s6_ff.cmd != rfvsl_pkg::CMD_LAND)
      |=> rsp_data.accel_sp_x == 16'sd0 && rsp_data.accel_sp_y == 16'sd0)
      else $error("acceleration setpoint nonzero outside landing");

   a_climb_zero_unless_descend: assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] && advance[6] && (s6_ff.cmd != rfvsl_pkg::CMD_DESCEND)
      && (s6_ff.cmd != rfvsl_pkg::CMD_DESCEND_NO_FF)
      |=> rsp_data.climb_sp == 16'sd0)
      else $error("climb setpoint nonzero outside descend modes");

endmodule

[bench/rotated_frame_velocity_setpoint_limiter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_frame_velocity_setpoint_limiter_top_tb
// Self-checking bench for the rotated-frame velocity setpoint limiter. A
// driver feeds request transfers from a queue with random gaps. Each accepted
// request goes through a bit-exact predictor: position-gain error,
// feedforward, heading rotation, per-axis clamp, back rotation and descent
// clamp. A monitor stalls the result side at random and compares every
// response field against the oldest prediction. Register settings change
// between phases while the pipeline is empty. The settings cover reset
// values, extremes, zero and crossed limits, and random values.
// ----------------------------------------------------------------------------
module rotated_frame_velocity_setpoint_limiter_top_tb;

   localparam logic [2:0]  CMD_RESERVED_LO = 3'd5;
   localparam logic [2:0]  CMD_RESERVED_HI = 3'd7;
   localparam logic [2:0]  CSR_UNMAPPED    = 3'd7;
   localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
   localparam logic [63:0] UNIT_Q30         = 64'h4000_0000;
   localparam int          PIPE_DRAIN      = 24;
   localparam int          MAX_WAIT        = 18;
   localparam int          MAX_PRINTED     = 60;
   localparam int          RANDOM_PHASES   = 10;
   localparam int          PHASE_ITEMS     = 103;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   rfvsl_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rfvsl_pkg::rsp_type rsp_data;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   logic [15:0] gain_shadow;
   logic [31:0] speed_lon_shadow;
   logic [31:0] speed_lat_shadow;
   logic [31:0] accel_lon_shadow;
   logic [31:0] accel_lat_shadow;
   logic [31:0] climb_lims_shadow;
   logic [14:0] descent_shadow;

   rfvsl_pkg::req_type queued_samples[$];
   rfvsl_pkg::rsp_type expected_setpoints[$];

   int mismatches;
   int sent;
   int checked;
   int phases;
   int cmd_seen[8];
   int in_gap;
   int in_calm;
   int out_stall;
   int out_calm;

   rotated_frame_velocity_setpoint_limiter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("timed out with %0d results outstanding", expected_setpoints.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Q1.14 sine of a phase where 2^32 is a full turn
   function automatic longint q14_sine(logic [31:0] phase);
      logic [63:0] frac;
      logic [63:0] ang;
      logic [63:0] term;
      logic [63:0] plus;
      logic [63:0] minus;
      logic [63:0] mag;
      int n;
      frac = {34'd0, phase[29:0]};
      if (phase[30]) begin
         frac = UNIT_Q30 - frac;
      end
      ang   = (frac * QUARTER_TURN_Q30) >> 30;
      term  = ang;
      plus  = ang;
      minus = 64'd0;
      for (n = 1; n <= 7; n++) begin
         term = (term * ang) >> 30;
         term = (term * ang) >> 30;
         term = term / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            minus = minus + term;
         end else begin
            plus = plus + term;
         end
      end
      mag = (plus > minus) ? plus - minus : 64'd0;
      if (mag > UNIT_Q30) begin
         mag = UNIT_Q30;
      end
      mag = (mag + 64'd32768) >> 16;
      return phase[31] ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint axis_clamp(longint v, logic [31:0] lims);
      longint hi;
      longint lo;
      hi = longint'($signed(lims[31:16]));
      lo = longint'($signed(lims[15:0]));
      if (v >= 0) begin
         return (v > hi) ? hi : v;
      end
      return (v < lo) ? lo : v;
   endfunction

   function automatic logic signed [15:0] to_q8_8(longint v);
      if (v > 32767) begin
         return 16'sh7FFF;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   // rotate into the heading frame, clamp each axis, rotate back
   function automatic void frame_bound(inout longint vx, inout longint vy,
                                       input logic [31:0] lon_lims,
                                       input logic [31:0] lat_lims,
                                       input longint sn, input longint cs);
      longint lon;
      longint lat;
      lon = axis_clamp(round_shr(vy * cs + vx * sn, 14), lon_lims);
      lat = axis_clamp(round_shr(vx * cs - vy * sn, 14), lat_lims);
      vx  = round_shr(lat * cs + lon * sn, 14);
      vy  = round_shr(lon * cs - lat * sn, 14);
   endfunction

   function automatic rfvsl_pkg::rsp_type bound_setpoints(rfvsl_pkg::req_type s);
      rfvsl_pkg::rsp_type o;
      logic [31:0] k;
      logic [31:0] phase;
      longint      sn;
      longint      cs;
      longint      sx;
      longint      sy;
      longint      ax;
      longint      ay;
      longint      climb;
      longint      hi;
      longint      lo;
      k     = 32'((longint'(s.heading) * rfvsl_pkg::SINE_TABLE_DEPTH) >> 16);
      phase = 32'((longint'(k) << 32) / rfvsl_pkg::SINE_TABLE_DEPTH);
      sn    = q14_sine(phase);
      cs    = q14_sine(phase + 32'h4000_0000);
      sx    = 0;
      sy    = 0;
      ax    = 0;
      ay    = 0;
      climb = 0;
      if (s.cmd <= rfvsl_pkg::CMD_DESCEND_NO_FF) begin
         sx = round_shr((longint'($signed(s.base_pos_x)) - longint'($signed(s.own_pos_x)))
                        * longint'(gain_shadow), 20);
         sy = round_shr((longint'($signed(s.base_pos_y)) - longint'($signed(s.own_pos_y)))
                        * longint'(gain_shadow), 20);
         if (s.cmd == rfvsl_pkg::CMD_TRACK || s.cmd == rfvsl_pkg::CMD_DESCEND) begin
            sx = sx + longint'($signed(s.base_vel_x));
            sy = sy + longint'($signed(s.base_vel_y));
         end
         frame_bound(sx, sy, speed_lon_shadow, speed_lat_shadow, sn, cs);
         if (s.cmd >= rfvsl_pkg::CMD_DESCEND) begin
            hi    = longint'($signed(climb_lims_shadow[31:16]));
            lo    = longint'($signed(climb_lims_shadow[15:0]));
            climb = -longint'(descent_shadow);
            if (climb > hi) begin
               climb = hi;
            end else if (climb < lo) begin
               climb = lo;
            end
         end
      end else if (s.cmd == rfvsl_pkg::CMD_LAND) begin
         sx = longint'($signed(s.base_vel_x));
         sy = longint'($signed(s.base_vel_y));
         ax = longint'($signed(s.base_acc_x));
         ay = longint'($signed(s.base_acc_y));
         frame_bound(sx, sy, speed_lon_shadow, speed_lat_shadow, sn, cs);
         frame_bound(ax, ay, accel_lon_shadow, accel_lat_shadow, sn, cs);
      end
      o.speed_sp_x = to_q8_8(sx);
      o.speed_sp_y = to_q8_8(sy);
      o.accel_sp_x = to_q8_8(ax);
      o.accel_sp_y = to_q8_8(ay);
      o.climb_sp   = to_q8_8(climb);
      return o;
   endfunction

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if ($urandom_range(0, 1) == 1) begin
         return $urandom_range(0, 2);
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("result %0d %s got %0d want %0d", checked, name,
                                 $signed(got), $signed(want)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         in_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_setpoints.push_back(bound_setpoints(req_data));
            cmd_seen[req_data.cmd]++;
            sent++;
            in_gap = draw_wait(in_calm);
         end
         if (req_valid && !req_ready) begin
            // hold until the transfer
         end else if (in_gap > 0) begin
            in_gap--;
            req_valid <= 1'b0;
         end else if (queued_samples.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= queued_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         out_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_setpoints.size() == 0) begin
               flag_mismatch("result transfer with nothing outstanding");
            end else begin
               rfvsl_pkg::rsp_type want;
               want = expected_setpoints.pop_front();
               check_field("speed_sp_x", rsp_data.speed_sp_x, want.speed_sp_x);
               check_field("speed_sp_y", rsp_data.speed_sp_y, want.speed_sp_y);
               check_field("accel_sp_x", rsp_data.accel_sp_x, want.accel_sp_x);
               check_field("accel_sp_y", rsp_data.accel_sp_y, want.accel_sp_y);
               check_field("climb_sp", rsp_data.climb_sp, want.climb_sp);
            end
            checked++;
            out_stall = draw_wait(out_calm);
         end
         rsp_ready <= (out_stall == 0);
         if (out_stall > 0) begin
            out_stall--;
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         rfvsl_pkg::CSR_POSITION_GAIN:     gain_shadow       = value[15:0];
         rfvsl_pkg::CSR_SPEED_LONG_LIMITS: speed_lon_shadow  = value;
         rfvsl_pkg::CSR_SPEED_LAT_LIMITS:  speed_lat_shadow  = value;
         rfvsl_pkg::CSR_ACCEL_LONG_LIMITS: accel_lon_shadow  = value;
         rfvsl_pkg::CSR_ACCEL_LAT_LIMITS:  accel_lat_shadow  = value;
         rfvsl_pkg::CSR_VERT_SPEED_LIMITS: climb_lims_shadow = value;
         rfvsl_pkg::CSR_DESCENT_RATE:      descent_shadow    = value[14:0];
         default: begin
         end
      endcase
   endtask

   task automatic program_limits(logic [31:0] gain, logic [31:0] spd_lon,
                                 logic [31:0] spd_lat, logic [31:0] acc_lon,
                                 logic [31:0] acc_lat, logic [31:0] climb_lims,
                                 logic [31:0] descent);
      write_csr(rfvsl_pkg::CSR_POSITION_GAIN, gain);
      write_csr(rfvsl_pkg::CSR_SPEED_LONG_LIMITS, spd_lon);
      write_csr(rfvsl_pkg::CSR_SPEED_LAT_LIMITS, spd_lat);
      write_csr(rfvsl_pkg::CSR_ACCEL_LONG_LIMITS, acc_lon);
      write_csr(rfvsl_pkg::CSR_ACCEL_LAT_LIMITS, acc_lat);
      write_csr(rfvsl_pkg::CSR_VERT_SPEED_LIMITS, climb_lims);
      write_csr(rfvsl_pkg::CSR_DESCENT_RATE, descent);
      write_csr(CSR_UNMAPPED, $urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      phases++;
   endtask

   task automatic settle();
      while (queued_samples.size() != 0 || expected_setpoints.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   function automatic logic [31:0] random_limits();
      if ($urandom_range(0, 2) == 0) begin
         return $urandom;
      end
      return {16'($urandom_range(0, 4095)), 16'(-int'($urandom_range(0, 4095)))};
   endfunction

   function automatic rfvsl_pkg::req_type make_sample(logic [2:0] cmd, logic [31:0] bpx,
                                                      logic [31:0] bpy, logic [31:0] opx,
                                                      logic [31:0] opy, logic [15:0] bvx,
                                                      logic [15:0] bvy, logic [15:0] bax,
                                                      logic [15:0] bay, logic [15:0] hdg);
      rfvsl_pkg::req_type s;
      s.cmd        = cmd;
      s.base_pos_x = bpx;
      s.base_pos_y = bpy;
      s.own_pos_x  = opx;
      s.own_pos_y  = opy;
      s.base_vel_x = bvx;
      s.base_vel_y = bvy;
      s.base_acc_x = bax;
      s.base_acc_y = bay;
      s.heading    = hdg;
      return s;
   endfunction

   function automatic logic [31:0] near_position(logic [31:0] own);
      case ($urandom_range(0, 3))
         0: return own + 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
         1: return own + 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] random_rate();
      if ($urandom_range(0, 2) != 0) begin
         return 16'(int'($urandom_range(0, 4096)) - 2048);
      end
      return 16'($urandom);
   endfunction

   function automatic rfvsl_pkg::req_type random_sample();
      logic [2:0]  cmd;
      logic [31:0] opx;
      logic [31:0] opy;
      if ($urandom_range(0, 15) == 0) begin
         cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      end else begin
         cmd = 3'($urandom_range(rfvsl_pkg::CMD_TRACK, rfvsl_pkg::CMD_LAND));
      end
      opx = $urandom;
      opy = $urandom;
      return make_sample(cmd, near_position(opx), near_position(opy), opx, opy,
                         random_rate(), random_rate(), random_rate(), random_rate(),
                         16'($urandom));
   endfunction

   initial begin
      int p;
      int i;
      logic [2:0] c;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      rsp_ready         = 1'b0;
      csr_we            = 1'b0;
      csr_index         = rfvsl_pkg::CSR_POSITION_GAIN;
      csr_wdata         = '0;
      gain_shadow       = rfvsl_pkg::POSITION_GAIN_RESET;
      speed_lon_shadow  = rfvsl_pkg::SPEED_LONG_LIMITS_RESET;
      speed_lat_shadow  = rfvsl_pkg::SPEED_LAT_LIMITS_RESET;
      accel_lon_shadow  = rfvsl_pkg::ACCEL_LONG_LIMITS_RESET;
      accel_lat_shadow  = rfvsl_pkg::ACCEL_LAT_LIMITS_RESET;
      climb_lims_shadow = rfvsl_pkg::VERT_SPEED_LIMITS_RESET;
      descent_shadow    = rfvsl_pkg::DESCENT_RATE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_TRACK,
         0, 0, 0, 0, 0, 0, 0, 0, 0));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_TRACK,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
         16'h7FFF, 16'h8000, 0, 0, 16'h2000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_TRACK_NO_FF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         16'h8000, 16'h7FFF, 0, 0, 16'hA000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_DESCEND,
         32'h0003_0000, 32'hFFFF_0000, 0, 0, 16'h0100, 16'hFF00, 0, 0, 16'h4000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_DESCEND_NO_FF,
         32'h0001_8000, 32'h0002_0000, 0, 0, 16'h7FFF, 16'h7FFF, 0, 0, 16'h8000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_DESCEND,
         32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
         16'h8000, 16'h8000, 0, 0, 16'hC000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_LAND,
         $urandom, $urandom, $urandom, $urandom,
         16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_LAND, 0, 0, 0, 0,
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_LAND, 0, 0, 0, 0,
         16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hC000));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_LAND, 0, 0, 0, 0,
         16'h0200, 16'hFE00, 16'h0080, 16'hFF80, 16'hFFFF));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_TRACK,
         32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 16'h00FF));
      queued_samples.push_back(make_sample(rfvsl_pkg::CMD_TRACK,
         32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 16'h0100));
      for (c = CMD_RESERVED_LO; c != rfvsl_pkg::CMD_TRACK; c++) begin
         queued_samples.push_back(make_sample(c, $urandom, $urandom, $urandom, $urandom,
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
      end
      for (c = rfvsl_pkg::CMD_TRACK; c <= rfvsl_pkg::CMD_LAND; c++) begin
         queued_samples.push_back(make_sample(c, $urandom, $urandom, $urandom, $urandom,
            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
      end
      settle();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_limits(32'hFFFF_FFFF, 32'h7FFF_8000, 32'h7FFF_8000, 32'h7FFF_8000,
                              32'h7FFF_8000, 32'h7FFF_8000, 32'hFFFF_FFFF);
            1: program_limits(32'hABCD_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                              32'hFFFF_8000);
            2: program_limits(32'h0000_1000, 32'h8000_7FFF, 32'h8000_7FFF, 32'h8000_7FFF,
                              32'h8000_7FFF, 32'h8000_7FFF, 32'h0000_0100);
            3: program_limits(32'h0000_FFFF, 32'h0001_FFFF, 32'hFF00_0100, 32'h0001_FFFF,
                              32'hFFF0_0010, 32'h0100_FF00, 32'h0000_7FFF);
            default: program_limits($urandom, random_limits(), random_limits(),
                                    random_limits(), random_limits(), random_limits(),
                                    $urandom);
         endcase
         @(negedge clock);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            queued_samples.push_back(random_sample());
         end
         settle();
      end

      $display("%0d requests over %0d register settings, %0d results compared",
               sent, phases + 1, checked);
      $display("track %0d, track no ff %0d, descend %0d, descend no ff %0d, land %0d",
               cmd_seen[rfvsl_pkg::CMD_TRACK], cmd_seen[rfvsl_pkg::CMD_TRACK_NO_FF],
               cmd_seen[rfvsl_pkg::CMD_DESCEND], cmd_seen[rfvsl_pkg::CMD_DESCEND_NO_FF],
               cmd_seen[rfvsl_pkg::CMD_LAND]);
      $display("reserved %0d", cmd_seen[CMD_RESERVED_LO] + cmd_seen[CMD_RESERVED_LO + 3'd1]
               + cmd_seen[CMD_RESERVED_HI]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
